// ===== hw/rtl/sliding_window_restart_limiter_core_assert.svh =====
// ----------------------------------------------------------------------------
// restart limiter assertion macros
// clocked implication checks, disabled while the active-low reset is low
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RESTART_LIMITER_CORE_ASSERT_SVH
`define SLIDING_WINDOW_RESTART_LIMITER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SWRL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SWRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SWRL_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SWRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/swrl_pkg.sv =====
// ----------------------------------------------------------------------------
// restart limiter package
// sizes, register codes, controller states and command/status types
// ----------------------------------------------------------------------------
`default_nettype none

package swrl_pkg;

    localparam int CHANNELS  = 256;
    localparam int LOG_DEPTH = 8;

    localparam int CH_FIELD_W = 8;
    localparam int NOW_W      = 32;
    localparam int WIN_W      = 16;
    localparam int LIM_W      = 4;
    localparam int OUT_CNT_W  = 4;

    localparam int CH_EXT_W = 13;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LD_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W    = $clog2(LOG_DEPTH + 1);
    localparam int CMP_W    = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int ADDR_W   = CH_W + LD_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd30;
    localparam logic [LIM_W-1:0] LIMIT_RESET  = 4'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_TAKE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic idle;
        logic load;
        logic cnt_rd;
        logic cnt_take;
        logic scan;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/sliding_window_restart_limiter_core.sv =====
// ----------------------------------------------------------------------------
// sliding window restart limiter core
// per-channel log of grant times, pruned by age, grants below the limit
//
// channel   direction  handshake               payload
// request   in         i_valid / o_stall       i_channel, i_now_seconds
// result    out        o_valid / i_stall       o_granted, o_recent_count
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a request passes through count read, count take, log scan and final update
// on its way to the result register; the log scan reads one logged time of
// its channel per cycle from the single read port
// reset clears the count store valid bits at once, no clearing pass
// the next request is taken while a result waits in the result register;
// a finished request holds in its last step while that register is full
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_restart_limiter_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [swrl_pkg::CH_FIELD_W-1:0]   i_channel,
    input  wire logic [swrl_pkg::NOW_W-1:0]        i_now_seconds,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_granted,
    output logic [swrl_pkg::OUT_CNT_W-1:0]         o_recent_count,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [swrl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [swrl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import swrl_pkg::*;

    `include "sliding_window_restart_limiter_core_assert.svh"

    logic [WIN_W-1:0]     r_window;
    logic [LIM_W-1:0]     r_limit;
    logic                 r_out_vld;
    logic                 r_out_granted;
    logic [OUT_CNT_W-1:0] r_out_count;

    t_cmd                 cmd;
    t_sts                 sts;
    logic                 accept;
    logic                 scan_done;
    logic                 dp_granted;
    logic [OUT_CNT_W-1:0] dp_count;

    assign o_cfg_ready    = 1'b1;
    assign o_stall        = !cmd.idle;
    assign accept         = i_valid && !o_stall;
    assign o_valid        = r_out_vld;
    assign o_granted      = r_out_granted;
    assign o_recent_count = r_out_count;

    assign sts.scan_done = scan_done;
    assign sts.out_free  = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_limit  <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_WINDOW: r_window <= i_cfg_data[WIN_W-1:0];
                REG_LIMIT:  r_limit  <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (cmd.fin) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.fin) begin
            r_out_granted <= dp_granted;
            r_out_count   <= dp_count;
        end
    end

    swrl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    swrl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_channel      (i_channel),
        .i_now_seconds  (i_now_seconds),
        .i_window       (r_window),
        .i_limit        (r_limit),
        .o_scan_done    (scan_done),
        .o_granted      (dp_granted),
        .o_recent_count (dp_count)
    );

    `SWRL_ASSERT_NEXT(a_fin_loads_result, i_clk, i_rst_n, cmd.fin, o_valid)
    `SWRL_ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, accept, o_stall)
    `SWRL_ASSERT_SAME(a_load_on_accept, i_clk, i_rst_n, cmd.load, i_valid && !o_stall)

endmodule

`default_nettype wire

// ===== hw/rtl/swrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// restart limiter controller
// sequences count read, log scan and final update for one request
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire swrl_pkg::t_sts i_sts,
    output swrl_pkg::t_cmd     o_cmd
);
    import swrl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) n_state = ST_CNT_RD;
            end
            ST_CNT_RD:   n_state = ST_CNT_TAKE;
            ST_CNT_TAKE: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_sts.scan_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.idle = 1'b1;
                o_cmd.load = i_accept;
            end
            ST_CNT_RD:   o_cmd.cnt_rd   = 1'b1;
            ST_CNT_TAKE: o_cmd.cnt_take = 1'b1;
            ST_SCAN:     o_cmd.scan     = 1'b1;
            ST_FIN:      o_cmd.fin      = i_sts.out_free;
            default:     o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/swrl_dp.sv =====
// ----------------------------------------------------------------------------
// restart limiter datapath
// count store with valid bits, grant time log memory, prune and decide logic
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire swrl_pkg::t_cmd                    i_cmd,
    input  wire logic [swrl_pkg::CH_FIELD_W-1:0]   i_channel,
    input  wire logic [swrl_pkg::NOW_W-1:0]        i_now_seconds,
    input  wire logic [swrl_pkg::WIN_W-1:0]        i_window,
    input  wire logic [swrl_pkg::LIM_W-1:0]        i_limit,
    output logic                                   o_scan_done,
    output logic                                   o_granted,
    output logic [swrl_pkg::OUT_CNT_W-1:0]         o_recent_count
);
    import swrl_pkg::*;

    localparam int LOG_WORDS = 2 ** ADDR_W;
    localparam logic [CH_EXT_W-1:0] CHAN_LIM  = CH_EXT_W'(CHANNELS);
    localparam logic [CNT_W-1:0]    DEPTH_CNT = CNT_W'(LOG_DEPTH);

    logic [NOW_W-1:0] r_log_mem [LOG_WORDS];
    logic [CNT_W-1:0] r_cnt_mem [CHANNELS];
    logic [CHANNELS-1:0] r_cnt_vld;

    logic [CH_W-1:0]  r_ch;
    logic             r_oor;
    logic [NOW_W-1:0] r_now;
    logic [CNT_W-1:0] r_cnt_q;
    logic             r_cnt_v;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_rd_i;
    logic [CNT_W-1:0] r_kept;
    logic             r_chk_vld;
    logic [NOW_W-1:0] r_rdata;

    logic [CH_EXT_W-1:0] ch_ext;
    logic [NOW_W-1:0]    age;
    logic                keep;
    logic                rd_more;
    logic [CMP_W-1:0]    kept_x;
    logic                grant;
    logic                append;
    logic [CNT_W-1:0]    kept_fin;
    logic [CMP_W-1:0]    kept_fin_x;
    logic                log_we;
    logic [ADDR_W-1:0]   log_waddr;
    logic [NOW_W-1:0]    log_wdata;
    logic [ADDR_W-1:0]   log_raddr;

    assign ch_ext  = {{(CH_EXT_W - CH_FIELD_W){1'b0}}, i_channel};
    assign age     = r_now - r_rdata;
    assign keep    = r_chk_vld && (age <= {{(NOW_W - WIN_W){1'b0}}, i_window});
    assign rd_more = r_rd_i < r_n;

    assign kept_x   = CMP_W'(r_kept);
    assign grant    = !r_oor && (kept_x < CMP_W'(i_limit));
    assign append   = grant && (r_kept < DEPTH_CNT);
    assign kept_fin = append ? r_kept + 1'b1 : r_kept;
    assign kept_fin_x = CMP_W'(kept_fin);

    assign o_scan_done    = !rd_more && !r_chk_vld;
    assign o_granted      = grant;
    assign o_recent_count = r_oor ? '0 : kept_fin_x[OUT_CNT_W-1:0];

    assign log_raddr = {r_ch, r_rd_i[LD_W-1:0]};

    always_comb begin
        log_we    = 1'b0;
        log_waddr = {r_ch, r_kept[LD_W-1:0]};
        log_wdata = r_rdata;
        if (i_cmd.scan && keep) begin
            log_we = 1'b1;
        end else if (i_cmd.fin && append) begin
            log_we    = 1'b1;
            log_wdata = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (log_we) begin
            r_log_mem[log_waddr] <= log_wdata;
        end
        if (i_cmd.scan && rd_more) begin
            r_rdata <= r_log_mem[log_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin && !r_oor) begin
            r_cnt_mem[r_ch] <= kept_fin;
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_q <= r_cnt_mem[r_ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (i_cmd.fin && !r_oor) begin
            r_cnt_vld[r_ch] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch  <= ch_ext[CH_W-1:0];
            r_oor <= ch_ext >= CHAN_LIM;
            r_now <= i_now_seconds;
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_v <= r_cnt_vld[r_ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= '0;
            r_rd_i    <= '0;
            r_kept    <= '0;
            r_chk_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_n       <= '0;
            r_rd_i    <= '0;
            r_kept    <= '0;
            r_chk_vld <= 1'b0;
        end else if (i_cmd.cnt_take) begin
            r_n <= (r_cnt_v && !r_oor) ? r_cnt_q : '0;
        end else if (i_cmd.scan) begin
            r_chk_vld <= rd_more;
            if (rd_more) begin
                r_rd_i <= r_rd_i + 1'b1;
            end
            if (keep) begin
                r_kept <= r_kept + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/restart_limiter_checker.sv =====
// ----------------------------------------------------------------------------
// restart limiter checker
// watches the request, result and config channels of the limiter core,
// keeps its own copy of the per-channel grant logs and registers, predicts
// each result and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module restart_limiter_checker
    import swrl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  o_stall,
    input  wire logic [CH_FIELD_W-1:0] i_channel,
    input  wire logic [NOW_W-1:0]      i_now_seconds,
    input  wire logic                  o_valid,
    input  wire logic                  i_stall,
    input  wire logic                  o_granted,
    input  wire logic [OUT_CNT_W-1:0]  o_recent_count,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 granted;
        logic [OUT_CNT_W-1:0] recent_count;
    } t_restart_result;

    t_restart_result  expected_results[$];
    logic [NOW_W-1:0] grant_times [CHANNELS][LOG_DEPTH];
    int               grant_counts [CHANNELS];
    logic [WIN_W-1:0] window_seconds = WINDOW_RESET;
    logic [LIM_W-1:0] grant_limit = LIMIT_RESET;
    int               errors = 0;

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    function automatic t_restart_result limit_restart(input logic [CH_FIELD_W-1:0] ch,
                                                      input logic [NOW_W-1:0] now);
        int               c;
        int               n;
        int               kept;
        logic [NOW_W-1:0] age;
        t_restart_result  res;
        c = int'(ch);
        res = '0;
        if (c >= CHANNELS) begin
            return res;
        end
        n = (grant_counts[c] > LOG_DEPTH) ? LOG_DEPTH : grant_counts[c];
        kept = 0;
        for (int i = 0; i < n; i++) begin
            age = now - grant_times[c][i];
            if (age <= NOW_W'(window_seconds)) begin
                grant_times[c][kept] = grant_times[c][i];
                kept++;
            end
        end
        if (kept < int'(grant_limit)) begin
            res.granted = 1'b1;
            // full log: granted but not logged
            if (kept < LOG_DEPTH) begin
                grant_times[c][kept] = now;
                kept++;
            end
        end
        grant_counts[c] = kept;
        res.recent_count = OUT_CNT_W'(kept);
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_restart_result want;
        if (!i_rst_n) begin
            foreach (grant_counts[c]) grant_counts[c] = 0;
            window_seconds = WINDOW_RESET;
            grant_limit = LIMIT_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_WINDOW) begin
                    window_seconds = i_cfg_data[WIN_W-1:0];
                end else if (i_cfg_index == REG_LIMIT) begin
                    grant_limit = i_cfg_data[LIM_W-1:0];
                end
            end
            if (i_valid && !o_stall) begin
                expected_results.push_back(limit_restart(i_channel, i_now_seconds));
            end
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    want = expected_results.pop_front();
                    if (o_granted !== want.granted) begin
                        report_mismatch($sformatf("granted %0b, expected %0b",
                                                  o_granted, want.granted));
                    end
                    if (o_recent_count !== want.recent_count) begin
                        report_mismatch($sformatf("recent_count %0d, expected %0d",
                                                  o_recent_count, want.recent_count));
                    end
                end
            end
        end
        o_pending = expected_results.size();
        o_errors = errors;
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// restart limiter testbench
// directed requests on limit, window edge, wrap, backward time and full log,
// then random request streams over several register settings and idling
// patterns; a checker beside the core predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swrl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENTS = 12;
    localparam int SEGMENT_ITEMS = 102;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [CH_FIELD_W-1:0] i_channel = '0;
    logic [NOW_W-1:0]      i_now_seconds = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_granted;
    logic [OUT_CNT_W-1:0]  o_recent_count;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors;
    int pending;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int cycles = 0;

    sliding_window_restart_limiter_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_channel      (i_channel),
        .i_now_seconds  (i_now_seconds),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_granted      (o_granted),
        .o_recent_count (o_recent_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    restart_limiter_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_channel      (i_channel),
        .i_now_seconds  (i_now_seconds),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_granted      (o_granted),
        .o_recent_count (o_recent_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < sink_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** sliding_window_restart_limiter_core: FAILED **");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_request(input logic [CH_FIELD_W-1:0] ch, input logic [NOW_W-1:0] now);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_channel = ch;
        i_now_seconds = now;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [NOW_W-1:0]      clock_now;
        logic [CH_FIELD_W-1:0] hot [4];
        logic [CH_FIELD_W-1:0] ch;
        logic [LIM_W-1:0]      limit;
        logic [WIN_W-1:0]      window;
        int                    r;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: fill to limit, deny, window edge, then expiry
        repeat (6) send_request(8'd0, 32'd100);
        send_request(8'd0, 32'd130);
        send_request(8'd0, 32'd131);
        // wrap of the time counter, then time going backwards
        send_request(8'd255, 32'hFFFF_FFFF);
        send_request(8'd255, 32'd5);
        send_request(8'd255, 32'd3);
        wait_drain();

        // zero limit denies everything
        write_register(REG_LIMIT, 16'h0000);
        send_request(8'd1, 32'd200);
        send_request(8'd0, 32'd140);
        wait_drain();

        // limit above log depth with widest window: log fills up
        write_register(REG_LIMIT, 16'hFFFF);
        write_register(REG_WINDOW, 16'hFFFF);
        repeat (10) send_request(8'd2, 32'd300);
        wait_drain();

        // zero window keeps only same-second grants
        write_register(REG_WINDOW, 16'h0000);
        write_register(REG_SPARE_A, 16'h1234);
        write_register(REG_SPARE_B, 16'hFFFF);
        send_request(8'd3, 32'd400);
        send_request(8'd3, 32'd400);
        wait_drain();

        clock_now = 32'd1000;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 4)
                0: begin
                    src_idle_pct = 18;
                    sink_idle_pct = 69;
                end
                1: begin
                    src_idle_pct = 69;
                    sink_idle_pct = 18;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            wait_drain();

            case (seg % 4)
                0: window = WIN_W'($urandom_range(5, 60));
                1: window = (seg % 8 == 1) ? 16'h0000 : 16'hFFFF;
                2: window = WIN_W'($urandom);
                default: window = WIN_W'($urandom_range(1, 300));
            endcase
            limit = (seg % 4 == 1) ? 4'd15 : LIM_W'($urandom_range(1, 8));
            write_register(REG_WINDOW, window);
            write_register(REG_LIMIT, {12'($urandom), limit});
            write_register((seg % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));

            for (int k = 0; k < 4; k++) hot[k] = 8'($urandom);
            if (seg % 3 == 2) begin
                clock_now = 32'hFFFF_FFC0;
            end

            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < 2) begin
                    clock_now += $urandom;
                end else if (r < 3) begin
                    clock_now -= $urandom_range(1, 100);
                end else begin
                    clock_now += $urandom_range(0, 3);
                end
                ch = ($urandom_range(99) < 80) ? hot[$urandom_range(0, 3)] : 8'($urandom);
                send_request(ch, clock_now);
                if ($urandom_range(199) == 0) begin
                    wait_drain();
                end
            end
        end

        wait_drain();
        if (errors == 0) begin
            $display("** sliding_window_restart_limiter_core: PASSED **");
        end else begin
            $display("** sliding_window_restart_limiter_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/swrl_pkg.sv
hw/rtl/swrl_ctrl.sv
hw/rtl/swrl_dp.sv
hw/rtl/sliding_window_restart_limiter_core.sv
test/restart_limiter_checker.sv
test/tb.sv
